// ===== rtl/core/scc_pkg.sv =====
package scc_pkg;

    localparam int DEF_MAX_VERTICES = 1024;
    localparam int DEF_MAX_EDGES    = 4096;

    // fixed field widths of the ports
    localparam int VC_W  = 11;
    localparam int ID_W  = 10;
    localparam int CNT_W = 11;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LD_WR,
        ST_CLR,
        ST_ROOT,
        ST_ROOT_CHK,
        ST_VISIT2,
        ST_STEP,
        ST_E_RD,
        ST_E_CHK,
        ST_FIN,
        ST_POP_RD,
        ST_POP_CLR,
        ST_RET,
        ST_RET2,
        ST_RET3,
        ST_DONE
    } walk_state_t;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] count;
        logic             dropped;
    } walk_res_t;

endpackage

// ===== rtl/core/scc_ram.sv =====
module scc_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);

    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/scc_walk.sv =====
module scc_walk #(
    parameter int MAX_VERTICES = scc_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = scc_pkg::DEF_MAX_EDGES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [$clog2(MAX_VERTICES):0]     n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              kind,
    input  logic [scc_pkg::ID_W-1:0]          from_vertex,
    input  logic [scc_pkg::ID_W-1:0]          to_vertex,
    input  logic                              out_busy,
    output scc_pkg::walk_res_t                res
);

    import scc_pkg::*;

    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int VNW = VW + 1;
    localparam int EW  = $clog2(MAX_EDGES);
    localparam int ETW = $clog2(MAX_EDGES + 1);
    localparam int NDW = 1 + 2 * VNW;
    localparam int HDW = 1 + EW;
    localparam int EDW = 1 + EW + VW;
    localparam int FRW = VW + 1 + EW;

    walk_state_t state_reg, state_next;
    logic [VNW-1:0] root_reg, root_next;
    logic [VNW-1:0] counter_reg, counter_next;
    logic [VNW-1:0] comps_reg, comps_next;
    logic [VNW-1:0] sp_reg, sp_next;
    logic [VNW-1:0] fp_reg, fp_next;
    logic [VW-1:0]  u_reg, u_next;
    logic [VW-1:0]  w_reg, w_next;
    logic           cur_valid_reg, cur_valid_next;
    logic [EW-1:0]  cur_reg, cur_next;
    logic [VNW-1:0] low_u_reg, low_u_next;
    logic [VNW-1:0] vis_u_reg, vis_u_next;
    logic [VNW-1:0] child_low_reg, child_low_next;
    logic           child_on_reg, child_on_next;
    logic [ETW-1:0] edge_total_reg, edge_total_next;
    logic           overflow_reg, overflow_next;
    logic [VW-1:0]  clr_idx_reg, clr_idx_next;
    logic [VW-1:0]  ld_from_reg, ld_from_next;
    logic [VW-1:0]  ld_to_reg, ld_to_next;

    logic           node_we, head_we, edge_we, cs_we, fr_we;
    logic [VW-1:0]  node_waddr, node_raddr, head_waddr, head_raddr;
    logic [VW-1:0]  cs_waddr, cs_raddr, fr_waddr, fr_raddr;
    logic [EW-1:0]  edge_waddr, edge_raddr;
    logic [NDW-1:0] node_wdata, node_rdata;
    logic [HDW-1:0] head_wdata, head_rdata;
    logic [EDW-1:0] edge_wdata, edge_rdata;
    logic [VW-1:0]  cs_wdata, cs_rdata;
    logic [FRW-1:0] fr_wdata, fr_rdata;

    logic           in_fire;
    logic           ids_ok;
    logic           nd_on;
    logic [VNW-1:0] nd_low, nd_vis;
    logic [VW-1:0]  e_target;
    logic [VW-1:0]  f_vertex;

    scc_ram #(.W(NDW), .D(MAX_VERTICES)) u_node_ram (
        .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
        .raddr(node_raddr), .rdata(node_rdata)
    );

    scc_ram #(.W(HDW), .D(MAX_VERTICES)) u_head_ram (
        .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .raddr(head_raddr), .rdata(head_rdata)
    );

    scc_ram #(.W(EDW), .D(MAX_EDGES)) u_edge_ram (
        .clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
        .raddr(edge_raddr), .rdata(edge_rdata)
    );

    scc_ram #(.W(VW), .D(MAX_VERTICES)) u_cstack_ram (
        .clk(clk), .we(cs_we), .waddr(cs_waddr), .wdata(cs_wdata),
        .raddr(cs_raddr), .rdata(cs_rdata)
    );

    scc_ram #(.W(FRW), .D(MAX_VERTICES)) u_frame_ram (
        .clk(clk), .we(fr_we), .waddr(fr_waddr), .wdata(fr_wdata),
        .raddr(fr_raddr), .rdata(fr_rdata)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign ids_ok   = (32'(from_vertex) < 32'(n)) && (32'(to_vertex) < 32'(n));

    assign nd_on    = node_rdata[2*VNW];
    assign nd_low   = node_rdata[2*VNW-1:VNW];
    assign nd_vis   = node_rdata[VNW-1:0];
    assign e_target = edge_rdata[VW-1:0];
    assign f_vertex = fr_rdata[FRW-1:EW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLR;
            root_reg       <= '0;
            counter_reg    <= '0;
            comps_reg      <= '0;
            sp_reg         <= '0;
            fp_reg         <= '0;
            edge_total_reg <= '0;
            overflow_reg   <= 1'b0;
            clr_idx_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            root_reg       <= root_next;
            counter_reg    <= counter_next;
            comps_reg      <= comps_next;
            sp_reg         <= sp_next;
            fp_reg         <= fp_next;
            edge_total_reg <= edge_total_next;
            overflow_reg   <= overflow_next;
            clr_idx_reg    <= clr_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg         <= u_next;
        w_reg         <= w_next;
        cur_valid_reg <= cur_valid_next;
        cur_reg       <= cur_next;
        low_u_reg     <= low_u_next;
        vis_u_reg     <= vis_u_next;
        child_low_reg <= child_low_next;
        child_on_reg  <= child_on_next;
        ld_from_reg   <= ld_from_next;
        ld_to_reg     <= ld_to_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        root_next       = root_reg;
        counter_next    = counter_reg;
        comps_next      = comps_reg;
        sp_next         = sp_reg;
        fp_next         = fp_reg;
        u_next          = u_reg;
        w_next          = w_reg;
        cur_valid_next  = cur_valid_reg;
        cur_next        = cur_reg;
        low_u_next      = low_u_reg;
        vis_u_next      = vis_u_reg;
        child_low_next  = child_low_reg;
        child_on_next   = child_on_reg;
        edge_total_next = edge_total_reg;
        overflow_next   = overflow_reg;
        clr_idx_next    = clr_idx_reg;
        ld_from_next    = ld_from_reg;
        ld_to_next      = ld_to_reg;

        node_we = 1'b0; node_waddr = '0; node_wdata = '0; node_raddr = '0;
        head_we = 1'b0; head_waddr = '0; head_wdata = '0; head_raddr = '0;
        edge_we = 1'b0; edge_waddr = '0; edge_wdata = '0; edge_raddr = '0;
        cs_we   = 1'b0; cs_waddr   = '0; cs_wdata   = '0; cs_raddr   = '0;
        fr_we   = 1'b0; fr_waddr   = '0; fr_wdata   = '0; fr_raddr   = '0;

        res = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (kind)
                    begin
                        root_next    = '0;
                        counter_next = VNW'(1);
                        comps_next   = '0;
                        sp_next      = '0;
                        fp_next      = '0;
                        state_next   = ST_ROOT;
                    end
                    else if (ids_ok)
                    begin
                        if (32'(edge_total_reg) >= MAX_EDGES)
                        begin
                            overflow_next = 1'b1;
                        end
                        else
                        begin
                            ld_from_next = VW'(from_vertex);
                            ld_to_next   = VW'(to_vertex);
                            head_raddr   = VW'(from_vertex);
                            state_next   = ST_LD_WR;
                        end
                    end
                end
            end

            ST_LD_WR:
            begin
                // new edge goes to the head of its source list
                edge_we         = 1'b1;
                edge_waddr      = EW'(edge_total_reg);
                edge_wdata      = {head_rdata, ld_to_reg};
                head_we         = 1'b1;
                head_waddr      = ld_from_reg;
                head_wdata      = {1'b1, EW'(edge_total_reg)};
                edge_total_next = edge_total_reg + 1'b1;
                state_next      = ST_IDLE;
            end

            ST_CLR:
            begin
                node_we      = 1'b1;
                node_waddr   = clr_idx_reg;
                head_we      = 1'b1;
                head_waddr   = clr_idx_reg;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == VW'(MAX_VERTICES - 1))
                begin
                    clr_idx_next = '0;
                    state_next   = ST_IDLE;
                end
            end

            ST_ROOT:
            begin
                if (root_reg == n)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    node_raddr = VW'(root_reg);
                    w_next     = VW'(root_reg);
                    state_next = ST_ROOT_CHK;
                end
            end

            ST_ROOT_CHK, ST_E_CHK:
            begin
                if (state_reg == ST_ROOT_CHK && nd_vis != '0)
                begin
                    root_next  = root_reg + 1'b1;
                    state_next = ST_ROOT;
                end
                else if (nd_vis == '0)
                begin
                    // open a new frame; the current one goes to the frame store
                    if (fp_reg != '0)
                    begin
                        fr_we    = 1'b1;
                        fr_waddr = VW'(fp_reg - 1'b1);
                        fr_wdata = {u_reg, cur_valid_reg, cur_reg};
                    end
                    fp_next      = fp_reg + 1'b1;
                    node_we      = 1'b1;
                    node_waddr   = w_reg;
                    node_wdata   = {1'b1, counter_reg, counter_reg};
                    cs_we        = 1'b1;
                    cs_waddr     = VW'(sp_reg);
                    cs_wdata     = w_reg;
                    sp_next      = sp_reg + 1'b1;
                    head_raddr   = w_reg;
                    low_u_next   = counter_reg;
                    vis_u_next   = counter_reg;
                    counter_next = counter_reg + 1'b1;
                    u_next       = w_reg;
                    state_next   = ST_VISIT2;
                end
                else
                begin
                    if (nd_on && nd_low < low_u_reg)
                    begin
                        low_u_next = nd_low;
                        node_we    = 1'b1;
                        node_waddr = u_reg;
                        node_wdata = {1'b1, nd_low, vis_u_reg};
                    end
                    state_next = ST_STEP;
                end
            end

            ST_VISIT2:
            begin
                cur_valid_next = head_rdata[EW];
                cur_next       = head_rdata[EW-1:0];
                state_next     = ST_STEP;
            end

            ST_STEP:
            begin
                if (cur_valid_reg)
                begin
                    edge_raddr = cur_reg;
                    state_next = ST_E_RD;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end

            ST_E_RD:
            begin
                cur_valid_next = edge_rdata[EW+VW];
                cur_next       = edge_rdata[EW+VW-1:VW];
                w_next         = e_target;
                if ({1'b0, e_target} >= n)
                begin
                    state_next = ST_STEP;
                end
                else
                begin
                    node_raddr = e_target;
                    state_next = ST_E_CHK;
                end
            end

            ST_FIN:
            begin
                child_low_next = low_u_reg;
                child_on_next  = (low_u_reg != vis_u_reg);
                if (low_u_reg == vis_u_reg)
                begin
                    comps_next = comps_reg + 1'b1;
                    cs_raddr   = VW'(sp_reg - 1'b1);
                    state_next = ST_POP_RD;
                end
                else
                begin
                    state_next = ST_RET;
                end
            end

            ST_POP_RD:
            begin
                w_next     = cs_rdata;
                sp_next    = sp_reg - 1'b1;
                node_raddr = cs_rdata;
                state_next = ST_POP_CLR;
            end

            ST_POP_CLR:
            begin
                node_we    = 1'b1;
                node_waddr = w_reg;
                node_wdata = {1'b0, nd_low, nd_vis};
                if (w_reg == u_reg)
                begin
                    state_next = ST_RET;
                end
                else
                begin
                    cs_raddr   = VW'(sp_reg - 1'b1);
                    state_next = ST_POP_RD;
                end
            end

            ST_RET:
            begin
                fp_next = fp_reg - 1'b1;
                if (fp_reg == VNW'(1))
                begin
                    root_next  = root_reg + 1'b1;
                    state_next = ST_ROOT;
                end
                else
                begin
                    fr_raddr   = VW'(fp_reg - VNW'(2));
                    state_next = ST_RET2;
                end
            end

            ST_RET2:
            begin
                u_next         = f_vertex;
                cur_valid_next = fr_rdata[EW];
                cur_next       = fr_rdata[EW-1:0];
                node_raddr     = f_vertex;
                state_next     = ST_RET3;
            end

            ST_RET3:
            begin
                vis_u_next = nd_vis;
                low_u_next = nd_low;
                // child still on the stack lowers the parent
                if (child_on_reg && child_low_reg < nd_low)
                begin
                    low_u_next = child_low_reg;
                    node_we    = 1'b1;
                    node_waddr = u_reg;
                    node_wdata = {1'b1, child_low_reg, nd_vis};
                end
                state_next = ST_STEP;
            end

            ST_DONE:
            begin
                if (!out_busy)
                begin
                    res.done        = 1'b1;
                    res.count       = CNT_W'(comps_reg);
                    res.dropped     = overflow_reg;
                    overflow_next   = 1'b0;
                    edge_total_next = '0;
                    clr_idx_next    = '0;
                    state_next      = ST_CLR;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/scc_counter.sv =====
// Counts the strongly connected components of a directed graph. Edge items
// (kind 0) are stored by reading the source vertex's list head, then writing
// the edge and the new head; edges with an id at or above vertex_count are
// ignored, and edges past the edge store's capacity are dropped and reported
// through edges_dropped with the next count. A finish item (kind 1) runs the
// component walk one memory step at a time. After the count is handed over,
// a clearing pass over all MAX_VERTICES vertex entries empties the graph; the
// same pass runs after reset. No item is accepted during the walk or the
// clearing pass. vertex_count may be written whenever the block is idle.
module scc_counter #(
    parameter int MAX_VERTICES = scc_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = scc_pkg::DEF_MAX_EDGES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [scc_pkg::VC_W-1:0]    cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        kind,
    input  logic [scc_pkg::ID_W-1:0]    from_vertex,
    input  logic [scc_pkg::ID_W-1:0]    to_vertex,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [scc_pkg::CNT_W-1:0]   component_count,
    output logic                        edges_dropped
);

    import scc_pkg::*;

    localparam int VNW = $clog2(MAX_VERTICES) + 1;

    logic [VC_W-1:0]  vertex_count_reg;
    logic [VNW-1:0]   n;
    logic             out_valid_reg;
    logic [CNT_W-1:0] count_reg;
    logic             dropped_reg;
    logic             out_busy;
    walk_res_t        res;

    assign cfg_ready = 1'b1;

    // vertex counts above capacity are clamped
    assign n = (32'(vertex_count_reg) > MAX_VERTICES) ? VNW'(MAX_VERTICES)
                                                       : VNW'(vertex_count_reg);

    assign out_busy = out_valid_reg && !out_ready;

    scc_walk #(
        .MAX_VERTICES(MAX_VERTICES),
        .MAX_EDGES   (MAX_EDGES)
    ) u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .n          (n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .from_vertex(from_vertex),
        .to_vertex  (to_vertex),
        .out_busy   (out_busy),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= VC_W'(1);
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                vertex_count_reg <= cfg_data;
            end
            if (res.done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.done)
        begin
            count_reg   <= res.count;
            dropped_reg <= res.dropped;
        end
    end

    assign out_valid       = out_valid_reg;
    assign component_count = count_reg;
    assign edges_dropped   = dropped_reg;

`ifndef SYNTHESIS
    // a new count never overwrites one that has not been transferred
    assert property (@(posedge clk) disable iff (!rst_n)
        res.done |-> !(out_valid_reg && !out_ready))
        else $error("count loaded over a pending result");

    // a finish item starts the walk, so input closes right after it
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && kind) |=> !in_ready)
        else $error("input open after finish transfer");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import scc_pkg::*;

    localparam int NV = DEF_MAX_VERTICES;
    localparam int NE = DEF_MAX_EDGES;
    localparam longint CYCLE_LIMIT = 64'd60_000_000;

    class scc_scoreboard;
        int unsigned nverts;
        int unsigned edge_dst[$];
        int unsigned edge_src[$];
        bit overflow;
        int unsigned pend_count[$];
        bit pend_drop[$];
        int errors;
        int checked;

        function void clear_graph();
            edge_dst.delete();
            edge_src.delete();
            overflow = 0;
        endfunction

        function int unsigned count_sccs(int unsigned n);
            int unsigned head[NV];
            int unsigned lnk[NV * 4];
            bit hv[NV];
            bit lv[NV * 4];
            int unsigned ord[NV];
            int unsigned low[NV];
            bit onst[NV];
            int unsigned stk[NV];
            int unsigned fv[NV];
            int unsigned fc[NV];
            bit fval[NV];
            int unsigned ctr, comps, sp, fp, u, v, e, p;
            ctr = 1; comps = 0; sp = 0; fp = 0;
            for (int i = 0; i < NV; i++)
            begin
                hv[i] = 0; ord[i] = 0; low[i] = 0; onst[i] = 0;
            end
            for (int i = 0; i < edge_dst.size(); i++)
            begin
                lnk[i] = head[edge_src[i]];
                lv[i] = hv[edge_src[i]];
                head[edge_src[i]] = i;
                hv[edge_src[i]] = 1;
            end
            for (int r = 0; r < n; r++)
            begin
                if (ord[r] != 0)
                    continue;
                ord[r] = ctr; low[r] = ctr; ctr++;
                stk[sp++] = r; onst[r] = 1;
                fv[0] = r; fc[0] = head[r]; fval[0] = hv[r]; fp = 1;
                while (fp > 0)
                begin
                    u = fv[fp-1];
                    if (fval[fp-1])
                    begin
                        e = fc[fp-1];
                        v = edge_dst[e];
                        fval[fp-1] = lv[e];
                        fc[fp-1] = lnk[e];
                        if (v >= n)
                            continue;
                        if (ord[v] == 0)
                        begin
                            if (fp >= NV || sp >= NV)
                                continue;
                            ord[v] = ctr; low[v] = ctr; ctr++;
                            stk[sp++] = v; onst[v] = 1;
                            fv[fp] = v; fc[fp] = head[v]; fval[fp] = hv[v]; fp++;
                        end
                        else if (onst[v] && low[v] < low[u])
                            low[u] = low[v];
                        continue;
                    end
                    if (low[u] == ord[u])
                    begin
                        comps++;
                        while (sp > 0)
                        begin
                            sp--;
                            v = stk[sp];
                            onst[v] = 0;
                            if (v == u)
                                break;
                        end
                    end
                    fp--;
                    if (fp > 0)
                    begin
                        p = fv[fp-1];
                        if (onst[u] && low[u] < low[p])
                            low[p] = low[u];
                    end
                end
            end
            return comps;
        endfunction

        function void note_item(bit k, int unsigned a, int unsigned b);
            int unsigned n;
            n = (nverts > NV) ? NV : nverts;
            if (k == 0)
            begin
                if (a >= n || b >= n)
                    return;
                if (edge_dst.size() >= NE)
                begin
                    overflow = 1;
                    return;
                end
                edge_src = {edge_src, a};
                edge_dst = {edge_dst, b};
            end
            else
            begin
                pend_count = {pend_count, count_sccs(n) & 11'h7ff};
                pend_drop = {pend_drop, overflow};
                clear_graph();
            end
        endfunction

        function bit check_result(int unsigned c, bit d, output string msg);
            int unsigned ec;
            bit ed;
            if (pend_count.size() == 0)
            begin
                msg = $sformatf("unexpected result count=%0d dropped=%0d", c, d);
                return 0;
            end
            ec = pend_count.pop_front();
            ed = pend_drop.pop_front();
            checked++;
            if (c != ec || d != ed)
            begin
                msg = $sformatf("result %0d: count %0d/%0d dropped %0d/%0d (got/exp)",
                                checked, c, ec, d, ed);
                return 0;
            end
            return 1;
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [VC_W-1:0] cfg_data = 0;
    logic in_valid = 0;
    logic in_ready;
    logic kind = 0;
    logic [ID_W-1:0] from_vertex = 0;
    logic [ID_W-1:0] to_vertex = 0;
    logic out_valid;
    logic out_ready = 0;
    logic [CNT_W-1:0] component_count;
    logic edges_dropped;

    scc_scoreboard sb;
    int fail_cnt = 0;
    int send_idle = 0;
    int recv_idle = 0;
    longint cycles = 0;
    int items_sent = 0;

    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    scc_counter DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .kind(kind),
        .from_vertex(from_vertex), .to_vertex(to_vertex),
        .out_valid(out_valid), .out_ready(out_ready),
        .component_count(component_count), .edges_dropped(edges_dropped)
    );

    task automatic report(input string msg);
        fail_cnt++;
        $display("mismatch: %s", msg);
    endtask

    // result side: sample at rising edge, change ready at falling edge
    always @(posedge clk)
    begin
        string msg;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
        else if (rst_n && out_valid && out_ready)
        begin
            if (!sb.check_result(component_count, edges_dropped, msg))
                report(msg);
        end
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle);

    // valid stays up into the next transfer unless the sender idles
    task automatic send_item(input bit k, input int unsigned a, input int unsigned b);
        while (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        kind <= k;
        from_vertex <= ID_W'(a);
        to_vertex <= ID_W'(b);
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_item(k, a, b);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 0;
        while (sb.pend_count.size() != 0)
            @(negedge clk);
        repeat (NV + 50)
            @(negedge clk);
    endtask

    task automatic write_vcount(input int unsigned val);
        wait_drained();
        cfg_valid <= 1;
        cfg_data <= VC_W'(val);
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.nverts = val & 11'h7ff;
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    // one graph: mostly in-range edges, a little noise, then finish
    task automatic random_graph(input int unsigned nv, input int unsigned ne);
        write_vcount(nv);
        for (int i = 0; i < ne; i++)
        begin
            if ($urandom_range(9) == 0)
                send_item(0, $urandom_range(1023), $urandom_range(1023));
            else
                send_item(0, $urandom_range(nv - 1), $urandom_range(nv - 1));
        end
        send_item(1, $urandom_range(1023), $urandom_range(1023));
    endtask

    initial
    begin
        int phase;
        sb = new();
        sb.nverts = 1;
        sb.clear_graph();
        repeat (3)
            @(negedge clk);
        rst_n = 1;

        // directed: reset count, single vertex, cycles, extremes
        send_item(1, 0, 0);
        send_item(0, 0, 0);
        send_item(1, 1023, 1023);
        write_vcount(0);
        send_item(0, 0, 0);
        send_item(1, 0, 0);
        write_vcount(4);
        send_item(0, 0, 1);
        send_item(0, 1, 2);
        send_item(0, 2, 0);
        send_item(0, 2, 3);
        send_item(0, 3, 1023);
        send_item(0, 1023, 3);
        send_item(1, 0, 0);
        write_vcount(1024);
        send_item(0, 1023, 0);
        send_item(0, 0, 1023);
        send_item(0, 682, 341);
        write_vcount(2047);
        send_item(0, 341, 682);
        // lowered count after edges stored
        write_vcount(600);
        send_item(1, 0, 0);
        write_vcount(8);
        for (int i = 0; i < 8; i++)
            send_item(0, i, (i + 1) % 8);
        write_vcount(3);
        send_item(1, 0, 0);

        for (phase = 0; phase < 3; phase++)
        begin
            send_idle = (phase == 0) ? 17 : (phase == 1) ? 62 : 0;
            recv_idle = (phase == 0) ? 62 : (phase == 1) ? 17 : 0;
            while (items_sent < 50 + (phase + 1) * 500)
            begin
                if ($urandom_range(39) == 0)
                    random_graph($urandom_range(1000, 1024), $urandom_range(20, 60));
                else
                    random_graph($urandom_range(1, 16), $urandom_range(0, 24));
            end
        end

        wait_drained();
        $display("run covered %0d items, %0d counts checked", items_sent, sb.checked);
        $display("vertex counts 0..2047, lowered counts and out-of-range ids");
        if (fail_cnt == 0 && sb.pend_count.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
